[rtl/core/prts_pkg.sv]
// prts_pkg: command, status and mode codes plus the wait-count memory request
// used by the priority round-robin task scheduler
// no dependencies
`timescale 1ns / 1ps
package prts_pkg;

  localparam logic [2:0] CMD_CREATE    = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_ACTIVATE  = 3'd2;
  localparam logic [2:0] CMD_TERMINATE = 3'd3;
  localparam logic [2:0] CMD_WAIT      = 3'd4;
  localparam logic [2:0] CMD_TICK      = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

  localparam logic [1:0] MODE_SUSPEND = 2'd0;
  localparam logic [1:0] MODE_WAITING = 2'd1;
  localparam logic [1:0] MODE_READY   = 2'd2;
  localparam logic [1:0] MODE_RUNNING = 2'd3;

  localparam logic [7:0] IDLE_PRIO = 8'd255;

  localparam int ADDR_W_MAX = 8;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W_MAX-1:0] addr;
    logic [31:0]           data;
  } mem_req_t;

endpackage

[rtl/core/prts_if.sv]
// prts_cmd_if and prts_res_if: valid/ready channels for command items and result items
// no dependencies
`timescale 1ns / 1ps
interface prts_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  task_sel;
  logic [7:0]  prio_in;
  logic [31:0] wait_ticks;
  modport source (output valid, cmd, task_sel, prio_in, wait_ticks, input ready);
  modport sink (input valid, cmd, task_sel, prio_in, wait_ticks, output ready);
endinterface

interface prts_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] task_out;
  logic       switched;
  logic [1:0] status;
  modport source (output valid, task_out, switched, status, input ready);
  modport sink (input valid, task_out, switched, status, output ready);
endinterface

[rtl/core/prts_wait_mem.sv]
// prts_wait_mem: per-slot timed-wait countdown memory, one port, registered read
// depends on prts_pkg
`timescale 1ns / 1ps
module prts_wait_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  prts_pkg::mem_req_t req,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.data;
    end
    rdata <= mem[req.addr[AW-1:0]];
  end

endmodule

[rtl/core/priority_round_robin_task_scheduler.sv]
// priority_round_robin_task_scheduler: top level, slot tables and command sequencer
// depends on prts_pkg, prts_if, prts_wait_mem
`timescale 1ns / 1ps
// One command item is taken at a time and answered with one result item. Create
// and unused codes go from execute straight to done; start, and activate, terminate
// and timed wait on a valid slot, run a min-priority pass and a ready-marking pass
// over the created slots, one slot per cycle, then a round-robin choice when one
// follows; tick runs the countdown pass (one memory read and one write-back per slot,
// paced by the single wait-count memory port) and both passes when any task wakes.
// The command channel is ready only while no result is pending.
module priority_round_robin_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input logic         clk,
  input logic         rst,
  prts_cmd_if.sink    cmd_ch,
  prts_res_if.source  res_ch
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int MW = prts_pkg::ADDR_W_MAX;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_TICK_RD = 4'd2;
  localparam logic [3:0] S_TICK_WB = 4'd3;
  localparam logic [3:0] S_MIN     = 4'd4;
  localparam logic [3:0] S_MARK    = 4'd5;
  localparam logic [3:0] S_CH_CUR  = 4'd6;
  localparam logic [3:0] S_CH_NXT  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] total;
  logic [SW-1:0] running;
  logic          os_started;
  logic [7:0]    prio [MAX_TASKS];
  logic [1:0]    mode [MAX_TASKS];
  logic          armed [MAX_TASKS];

  logic [2:0]    cmd_q;
  logic [8:0]    sel_q;
  logic [7:0]    prio_q;
  logic [31:0]   ticks_q;
  logic [CW-1:0] idx;
  logic [8:0]    best;
  logic          found;
  logic [SW-1:0] first;
  logic          woke;
  logic          keep;
  logic          cur_act;
  logic [7:0]    cur_prio;
  logic [SW-1:0] nxt;

  logic          res_valid;
  logic [SW-1:0] shown;
  logic          created;
  logic          switched_q;
  logic [1:0]    status_q;

  logic [SW-1:0] rd_addr;
  logic [7:0]    prio_rd;
  logic [1:0]    mode_rd;
  logic          armed_rd;
  logic [31:0]   mem_rdata;
  logic [31:0]   dec;
  logic          last;
  logic          sel_bad;
  logic [SW-1:0] sel_idx;
  logic [SW-1:0] tslot;
  logic          count_hit;
  logic          wake_now;
  logic [SW+3:0] shown_ext;
  prts_pkg::mem_req_t mem_req;

  prts_wait_mem #(.DEPTH(MAX_TASKS), .AW(SW)) u_wait_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_comb begin
    unique case (state)
      S_CH_CUR: rd_addr = running;
      S_CH_NXT: rd_addr = nxt;
      default:  rd_addr = idx[SW-1:0];
    endcase
  end

  assign prio_rd   = prio[rd_addr];
  assign mode_rd   = mode[rd_addr];
  assign armed_rd  = armed[rd_addr];
  assign dec       = mem_rdata - 32'd1;
  assign last      = (idx + CW'(1)) == total;
  assign sel_bad   = sel_q >= 9'(total);
  assign sel_idx   = sel_q[SW-1:0];
  assign tslot     = total[SW-1:0];
  assign count_hit = (mode_rd == prts_pkg::MODE_SUSPEND) && armed_rd;
  assign wake_now  = count_hit && (dec == 32'd1);

  always_comb begin
    mem_req      = '0;
    mem_req.addr = MW'(idx[SW-1:0]);
    if (state == S_EXEC) begin
      if (cmd_q == prts_pkg::CMD_CREATE && total < CW'(MAX_TASKS)) begin
        mem_req.we   = 1'b1;
        mem_req.addr = MW'(tslot);
      end else if (cmd_q == prts_pkg::CMD_WAIT && !sel_bad) begin
        mem_req.we   = 1'b1;
        mem_req.addr = MW'(sel_idx);
        mem_req.data = ticks_q;
      end
    end else if (state == S_TICK_WB && count_hit) begin
      mem_req.we   = 1'b1;
      mem_req.data = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= CW'(1);
      running    <= '0;
      os_started <= 1'b0;
      res_valid  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        prio[i]  <= (i == 0) ? prts_pkg::IDLE_PRIO : 8'd0;
        mode[i]  <= prts_pkg::MODE_SUSPEND;
        armed[i] <= 1'b0;
      end
    end else begin
      if (res_valid && res_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_ch.valid && cmd_ch.ready) begin
            cmd_q      <= cmd_ch.cmd;
            sel_q      <= 9'(cmd_ch.task_sel);
            prio_q     <= cmd_ch.prio_in;
            ticks_q    <= cmd_ch.wait_ticks;
            status_q   <= prts_pkg::ST_OK;
            switched_q <= 1'b0;
            created    <= 1'b0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx   <= '0;
          best  <= 9'd256;
          found <= 1'b0;
          woke  <= 1'b0;
          case (cmd_q) inside
            prts_pkg::CMD_CREATE: begin
              if (total >= CW'(MAX_TASKS)) begin
                status_q <= prts_pkg::ST_FULL;
              end else begin
                prio[tslot]  <= prio_q;
                mode[tslot]  <= prts_pkg::MODE_SUSPEND;
                armed[tslot] <= 1'b0;
                total        <= total + CW'(1);
                created      <= 1'b1;
                shown        <= tslot;
              end
              state <= S_DONE;
            end
            prts_pkg::CMD_START: begin
              os_started <= 1'b1;
              running    <= '0;
              mode[0]    <= prts_pkg::MODE_WAITING;
              state      <= S_MIN;
            end
            prts_pkg::CMD_ACTIVATE, prts_pkg::CMD_TERMINATE, prts_pkg::CMD_WAIT: begin
              if (sel_bad) begin
                status_q <= prts_pkg::ST_NO_SLOT;
                state    <= S_DONE;
              end else begin
                mode[sel_idx] <= (cmd_q == prts_pkg::CMD_ACTIVATE) ?
                                 prts_pkg::MODE_WAITING : prts_pkg::MODE_SUSPEND;
                if (cmd_q == prts_pkg::CMD_WAIT) begin
                  armed[sel_idx] <= 1'b1;
                end
                state <= S_MIN;
              end
            end
            prts_pkg::CMD_TICK: state <= S_TICK_RD;
            default: state <= S_DONE;
          endcase
        end
        S_TICK_RD: state <= S_TICK_WB;
        S_TICK_WB: begin
          if (wake_now) begin
            armed[idx[SW-1:0]] <= 1'b0;
            mode[idx[SW-1:0]]  <= prts_pkg::MODE_WAITING;
            woke               <= 1'b1;
          end
          if (last) begin
            idx   <= '0;
            state <= (woke || wake_now) ? S_MIN : S_DONE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_TICK_RD;
          end
        end
        S_MIN: begin
          if (mode_rd != prts_pkg::MODE_SUSPEND && 9'(prio_rd) < best) begin
            best <= 9'(prio_rd);
          end
          if (last) begin
            idx   <= '0;
            state <= S_MARK;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_MARK: begin
          if (mode_rd != prts_pkg::MODE_SUSPEND && 9'(prio_rd) == best) begin
            mode[idx[SW-1:0]] <= prts_pkg::MODE_READY;
            if (!found) begin
              first <= idx[SW-1:0];
              found <= 1'b1;
            end
          end
          if (last) begin
            state <= ((cmd_q == prts_pkg::CMD_ACTIVATE || cmd_q == prts_pkg::CMD_TERMINATE ||
                       cmd_q == prts_pkg::CMD_WAIT) && os_started && running != '0) ?
                     S_CH_CUR : S_DONE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_CH_CUR: begin
          cur_act  <= mode_rd != prts_pkg::MODE_SUSPEND;
          cur_prio <= prio_rd;
          if (!found && mode_rd != prts_pkg::MODE_SUSPEND) begin
            keep <= 1'b1;
            nxt  <= running;
          end else begin
            keep <= 1'b0;
            nxt  <= found ? first : '0;
          end
          state <= S_CH_NXT;
        end
        S_CH_NXT: begin
          // current task returns to ready if active, not kept, of chosen priority
          if (!keep && cur_prio == prio_rd && (nxt == running || cur_act)) begin
            mode[running] <= prts_pkg::MODE_READY;
            if (nxt != running) begin
              mode[nxt] <= prts_pkg::MODE_RUNNING;
            end
          end else begin
            mode[nxt] <= prts_pkg::MODE_RUNNING;
          end
          running    <= nxt;
          switched_q <= 1'b1;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!created) begin
            shown <= running;
          end
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign shown_ext       = (SW + 4)'(shown);
  assign cmd_ch.ready    = (state == S_IDLE) && !res_valid;
  assign res_ch.valid    = res_valid;
  assign res_ch.task_out = shown_ext[3:0];
  assign res_ch.switched = switched_q;
  assign res_ch.status   = status_q;

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total != '0 && total <= CW'(MAX_TASKS))
    else $error("slot count out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(res_ch.valid && cmd_ch.ready))
    else $error("command taken while a result is pending");

  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> res_ch.valid)
    else $error("result not shown after sequence end");

  a_switch_started: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid && res_ch.switched |-> os_started && res_ch.status == prts_pkg::ST_OK)
    else $error("switch reported before start or on error");

endmodule
